// ----- hw/rtl/btlv_pkg.sv -----
// btlv_pkg: shared types and constants for the BER TLV header parser
`default_nettype none

package btlv_pkg;

   // long-form length may carry at most this many bytes
   localparam int MAX_LEN_BYTES = 8;

   localparam int DATA_W   = 8;
   localparam int LEFT_W   = 16;
   localparam int LENGTH_W = 16;
   localparam int PEND_W   = 4;

   // tag byte whose low five bits are all ones means high tag number form
   localparam logic [4:0] HIGH_TAG_MARK = 5'h1f;

   typedef enum logic [2:0] {
      PH_TAG       = 3'd0,
      PH_LEN_FIRST = 3'd1,
      PH_LEN_LONG  = 3'd2,
      PH_VALUE     = 3'd3,
      PH_ERROR     = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      KIND_TAG     = 3'd0,
      KIND_LEN     = 3'd1,
      KIND_VALUE   = 3'd2,
      KIND_ERROR   = 3'd3,
      KIND_IGNORED = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE     = 3'd0,
      ERR_TRUNC    = 3'd1,
      ERR_HIGH_TAG = 3'd2,
      ERR_INDEF    = 3'd3,
      ERR_WIDE     = 3'd4,
      ERR_OVER     = 3'd5
   } err_type;

   // one input word
   typedef struct packed {
      logic [DATA_W-1:0] data_byte;
      logic              buffer_start;
      logic [LEFT_W-1:0] bytes_left;
   } item_type;

   // one result word
   typedef struct packed {
      kind_type            byte_kind;
      logic [DATA_W-1:0]   byte_out;
      logic [DATA_W-1:0]   header_tag;
      logic [LENGTH_W-1:0] header_length;
      logic                header_done;
      logic                value_last;
      err_type             error_code;
   } result_type;

endpackage

`default_nettype wire

// ----- hw/rtl/ber_tlv_header_parser_core.sv -----
// ber_tlv_header_parser_core: top level of the BER TLV header parser
//
//   channel   dir   handshake             payload
//   req       in    req_tvalid/tready     tdata[23:0], tuser[0]
//   rsp       out   rsp_tvalid/tready     tdata[39:0], tuser[3:0], tlast
//
// one byte word accepted per cycle while rsp is not stalled, one result word per byte
// rsp_tvalid follows req acceptance through the input register, then the result register
// the header state update is one pass of logic between the two registers
// synchronous active-high reset empties both registers and returns to the tag phase
// a stalled rsp still lets one more req word into the input register
`default_nettype none

module ber_tlv_header_parser_core #(
   parameter int MAX_LENGTH_BYTES = btlv_pkg::MAX_LEN_BYTES
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // data_byte[7:0], bytes_left[23:8]
   input  wire logic [0:0]  req_tuser,   // buffer_start[0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // byte_out[7:0], header_tag[15:8],
                                         // header_length[31:16], error_code[34:32]
   output logic [3:0]       rsp_tuser,   // byte_kind[2:0], header_done[3]
   output logic             rsp_tlast    // value_last
);
   import btlv_pkg::*;

   item_type   in_item;
   item_type   item;
   logic       item_valid;
   logic       item_take;
   logic       res_ready;
   result_type result;
   result_type out_word;

   // unpack the input word
   assign in_item.data_byte    = req_tdata[7:0];
   assign in_item.bytes_left   = req_tdata[23:8];
   assign in_item.buffer_start = req_tuser[0];

   assign item_take = item_valid && res_ready;

   btlv_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (in_item),
      .item_valid (item_valid),
      .item_take  (item_take),
      .item       (item)
   );

   btlv_step #(
      .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
   ) u_step (
      .clock   (clock),
      .reset   (reset),
      .advance (item_take),
      .item    (item),
      .result  (result)
   );

   btlv_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .res_valid (item_valid),
      .res_ready (res_ready),
      .res_word  (result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_word  (out_word)
   );

   // pack the result word
   assign rsp_tdata = {5'd0, out_word.error_code, out_word.header_length,
                       out_word.header_tag, out_word.byte_out};
   assign rsp_tuser = {out_word.header_done, out_word.byte_kind};
   assign rsp_tlast = out_word.value_last;

endmodule

`default_nettype wire

// ----- hw/rtl/btlv_in_stage.sv -----
// btlv_in_stage: input register holding one accepted word
`default_nettype none

module btlv_in_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire btlv_pkg::item_type in_item,
   output logic                   item_valid,
   input  wire logic              item_take,
   output btlv_pkg::item_type     item
);
   import btlv_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   // accept when empty or when the held word leaves this cycle
   assign in_ready   = !valid_ff || item_take;
   assign valid_in   = (in_valid && in_ready) || (valid_ff && !item_take);
   assign item_valid = valid_ff;
   assign item       = item_ff;

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/btlv_step.sv -----
// btlv_step: parser state and per-byte decode logic
`default_nettype none

module btlv_step #(
   parameter int MAX_LENGTH_BYTES = btlv_pkg::MAX_LEN_BYTES
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire btlv_pkg::item_type item,
   output btlv_pkg::result_type    result
);
   import btlv_pkg::*;

   phase_type             phase_ff, phase_in;
   logic [DATA_W-1:0]     tag_ff, tag_in;
   logic [PEND_W-1:0]     pend_ff, pend_in;
   logic [LENGTH_W-1:0]   acc_ff, acc_in;
   logic                  ovf_ff, ovf_in;
   logic [LENGTH_W-1:0]   rem_ff, rem_in;

   phase_type             ph;
   logic [DATA_W-1:0]     data_byte;
   logic [LEFT_W-1:0]     left;
   logic                  tag_trunc;
   logic                  tag_high;
   logic                  len_short;
   logic [6:0]            len_count;
   logic                  len_indef;
   logic                  len_wide;
   logic                  len_trunc;
   logic [LENGTH_W-1:0]   acc_shift;
   logic                  ovf_shift;
   logic                  long_final;
   logic [LENGTH_W-1:0]   fin_len;
   logic                  fin_ovf;
   logic                  fin_over;
   logic                  value_end;

   // a buffer start forces the tag phase
   assign ph        = item.buffer_start ? PH_TAG : phase_ff;
   assign data_byte = item.data_byte;
   assign left      = item.bytes_left;

   // tag checks
   assign tag_trunc = (left == '0);
   assign tag_high  = (data_byte[4:0] == HIGH_TAG_MARK);

   // first length byte checks
   assign len_short = !data_byte[7];
   assign len_count = data_byte[6:0];
   assign len_indef = (len_count == '0);
   assign len_wide  = (len_count > 7'(MAX_LENGTH_BYTES));
   assign len_trunc = ({9'd0, len_count} > left);

   // long-form accumulation, upper bits folded into an overflow flag
   assign acc_shift  = {acc_ff[LENGTH_W-DATA_W-1:0], data_byte};
   assign ovf_shift  = ovf_ff || (acc_ff[LENGTH_W-1:LENGTH_W-DATA_W] != '0);
   assign long_final = (pend_ff <= PEND_W'(1));

   // length that completes the header and its check against the buffer
   assign fin_len  = (ph == PH_LEN_FIRST) ? {8'd0, data_byte} : acc_shift;
   assign fin_ovf  = (ph == PH_LEN_FIRST) ? 1'b0 : ovf_shift;
   assign fin_over = fin_ovf || (fin_len > left);

   assign value_end = (rem_ff <= LENGTH_W'(1));

   // next state
   always_comb begin
      phase_in = ph;
      tag_in   = tag_ff;
      pend_in  = pend_ff;
      acc_in   = acc_ff;
      ovf_in   = ovf_ff;
      rem_in   = rem_ff;
      case (ph)
         PH_TAG: begin
            tag_in = data_byte;
            if (tag_trunc || tag_high) begin
               phase_in = PH_ERROR;
            end else begin
               phase_in = PH_LEN_FIRST;
            end
         end
         PH_LEN_FIRST: begin
            if (len_short) begin
               if (fin_over) begin
                  phase_in = PH_ERROR;
               end else if (fin_len == '0) begin
                  phase_in = PH_TAG;
               end else begin
                  phase_in = PH_VALUE;
                  rem_in   = fin_len;
               end
            end else if (len_indef || len_wide || len_trunc) begin
               phase_in = PH_ERROR;
            end else begin
               pend_in  = len_count[PEND_W-1:0];
               acc_in   = '0;
               ovf_in   = 1'b0;
               phase_in = PH_LEN_LONG;
            end
         end
         PH_LEN_LONG: begin
            acc_in = acc_shift;
            ovf_in = ovf_shift;
            if (pend_ff != '0) begin
               pend_in = pend_ff - PEND_W'(1);
            end
            if (long_final) begin
               if (fin_over) begin
                  phase_in = PH_ERROR;
               end else if (fin_len == '0) begin
                  phase_in = PH_TAG;
               end else begin
                  phase_in = PH_VALUE;
                  rem_in   = fin_len;
               end
            end
         end
         PH_VALUE: begin
            if (rem_ff != '0) begin
               rem_in = rem_ff - LENGTH_W'(1);
            end
            if (value_end) begin
               phase_in = PH_TAG;
            end
         end
         default: begin
            phase_in = PH_ERROR;
         end
      endcase
   end

   // result for this byte
   always_comb begin
      result               = '0;
      result.byte_kind     = KIND_LEN;
      result.byte_out      = data_byte;
      result.header_tag    = tag_ff;
      result.error_code    = ERR_NONE;
      case (ph)
         PH_TAG: begin
            result.header_tag = data_byte;
            if (tag_trunc) begin
               result.byte_kind  = KIND_ERROR;
               result.error_code = ERR_TRUNC;
            end else if (tag_high) begin
               result.byte_kind  = KIND_ERROR;
               result.error_code = ERR_HIGH_TAG;
            end else begin
               result.byte_kind  = KIND_TAG;
            end
         end
         PH_LEN_FIRST, PH_LEN_LONG: begin
            if ((ph == PH_LEN_FIRST) && !len_short) begin
               if (len_indef) begin
                  result.byte_kind  = KIND_ERROR;
                  result.error_code = ERR_INDEF;
               end else if (len_wide) begin
                  result.byte_kind  = KIND_ERROR;
                  result.error_code = ERR_WIDE;
               end else if (len_trunc) begin
                  result.byte_kind  = KIND_ERROR;
                  result.error_code = ERR_TRUNC;
               end
            end else if ((ph == PH_LEN_FIRST) || long_final) begin
               if (fin_over) begin
                  result.byte_kind  = KIND_ERROR;
                  result.error_code = ERR_OVER;
               end else begin
                  result.header_length = fin_len;
                  result.header_done   = 1'b1;
                  result.value_last    = (fin_len == '0);
               end
            end
         end
         PH_VALUE: begin
            result.byte_kind  = KIND_VALUE;
            result.value_last = value_end;
         end
         default: begin
            result.byte_kind = KIND_IGNORED;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TAG;
      end else if (advance) begin
         phase_ff <= phase_in;
      end
   end

   // header working registers
   always_ff @(posedge clock) begin
      if (advance) begin
         tag_ff  <= tag_in;
         pend_ff <= pend_in;
         acc_ff  <= acc_in;
         ovf_ff  <= ovf_in;
         rem_ff  <= rem_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/btlv_out_stage.sv -----
// btlv_out_stage: result register towards the output channel
`default_nettype none

module btlv_out_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 res_valid,
   output logic                      res_ready,
   input  wire btlv_pkg::result_type res_word,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output btlv_pkg::result_type      out_word
);
   import btlv_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type word_ff;

   // take a new word when empty or when the held one is taken
   assign res_ready = !valid_ff || out_ready;
   assign valid_in  = (res_valid && res_ready) || (valid_ff && !out_ready);
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         word_ff <= res_word;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/btlv_checker.sv -----
// btlv_checker: port-level assertions for the BER TLV header parser, bound to the top
`default_nettype none

module btlv_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [23:0] req_tdata,
   input wire logic [0:0]  req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata,
   input wire logic [3:0]  rsp_tuser,
   input wire logic        rsp_tlast
);
   import btlv_pkg::*;

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp word changed while stalled");

   // error code is set exactly on error words
   a_err_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tuser[2:0] == KIND_ERROR) == (rsp_tdata[34:32] != ERR_NONE)))
      else $error("error code and byte kind disagree");

   // a header completes only on a length byte
   a_done_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[3] |-> (rsp_tuser[2:0] == KIND_LEN))
      else $error("header done on a non-length byte");

   // length is shown only with header done
   a_len_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[3] |-> (rsp_tdata[31:16] == 16'd0))
      else $error("header length without header done");

   // last marks a value byte or an empty item header
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> (rsp_tuser[2:0] == KIND_VALUE)
         || (rsp_tuser[3] && (rsp_tdata[31:16] == 16'd0)))
      else $error("last on an unexpected word");

endmodule

bind ber_tlv_header_parser_core btlv_checker u_btlv_checker (.*);

`default_nettype wire
